FILE: sv/fehp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fehp_pkg
// Shared constants for the free-extent heap allocator.
// ----------------------------------------------------------------------------
package fehp_pkg;

	localparam int MAX_EXTENTS = 32;
	localparam int IDX_W       = $clog2(MAX_EXTENTS);
	localparam int CNT_W       = $clog2(MAX_EXTENTS + 1);
	localparam int TOTAL_W     = 32 + IDX_W + 1;

	localparam logic [31:0] HEADER_BYTES = 32'd8;
	localparam logic [31:0] EXTENT_BYTES = 32'd12;
	localparam logic [3:0]  MERGE_PERIOD = 4'd10;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_NO_SPACE   = 2'd1;
	localparam logic [1:0] ST_TABLE_FULL = 2'd2;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	localparam logic REG_HEAP_BASE = 1'b0;
	localparam logic REG_HEAP_SIZE = 1'b1;

	typedef struct packed {
		logic [31:0] start_addr;
		logic [31:0] end_addr;
	} extent_t;

endpackage

FILE: sv/fehp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fehp_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module fehp_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: sv/free_extent_heap_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free_extent_heap_allocator
// First-fit free-extent allocator with merging, table kept in one RAM.
// ----------------------------------------------------------------------------
// The free-extent table lives in a 32-entry RAM with one read and one write
// port, walked by a sequencer that reads each entry it touches, then tests
// and writes it back. An allocation scans the table and shifts the later
// entries when an extent is removed whole; a free scans the table and shifts
// the entries when it goes to the head. A full merge pass runs on every
// eleventh free and before the retry of a failed allocation. Requests are
// taken one at a time; a finished result sits in an output register so the
// next request can be accepted while it waits. After reset and after any
// register write the block rebuilds entry 0 before it returns to idle.
// ----------------------------------------------------------------------------
module free_extent_heap_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [31:0] request_size,
	input  logic [31:0] user_address,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] result_address,
	output logic [1:0]  status
);

	import fehp_pkg::*;

	typedef enum logic [18:0] {
		S_INIT   = 19'h00001,
		S_IDLE   = 19'h00002,
		S_A_RD   = 19'h00004,
		S_A_CHK  = 19'h00008,
		S_SHD_RD = 19'h00010,
		S_SHD_WR = 19'h00020,
		S_F_RD   = 19'h00040,
		S_F_CHK  = 19'h00080,
		S_SHU_RD = 19'h00100,
		S_SHU_WR = 19'h00200,
		S_F_HEAD = 19'h00400,
		S_F_POST = 19'h00800,
		S_CI_RD  = 19'h01000,
		S_CI_LD  = 19'h02000,
		S_CJ_RD  = 19'h04000,
		S_CJ_CHK = 19'h08000,
		S_CP_RD  = 19'h10000,
		S_CP_CHK = 19'h20000,
		S_DONE   = 19'h40000
	} state_t;

	state_t             state_q;
	logic [31:0]        base_q, size_q;
	logic [CNT_W-1:0]   count_q, i_q, j_q, w_q;
	logic [3:0]         frees_q;
	logic [32:0]        need_q;
	logic [31:0]        from_q, fend_q;
	logic [TOTAL_W-1:0] total_q;
	logic               retry_q, cret_alloc_q;
	logic [31:0]        si_q, ei_q;
	logic [31:0]        res_addr_q;
	logic [1:0]         res_status_q;
	logic [31:0]        result_address_q;
	logic [1:0]         status_q;
	logic               out_valid_q;

	logic             rd_en, wr_en;
	logic [IDX_W-1:0] rd_addr, wr_addr;
	extent_t          wr_data, rd_data;

	logic [31:0] avail;
	logic        fits_carve, fits_whole;
	logic [3:0]  frees_inc;
	logic        out_free;

	assign avail      = rd_data.end_addr - rd_data.start_addr;
	assign fits_carve = {2'b00, avail} > ({1'b0, need_q} + {2'b00, EXTENT_BYTES});
	assign fits_whole = {1'b0, avail} >= need_q;
	assign frees_inc  = frees_q + 4'd1;
	assign out_free   = !out_valid_q || !out_stall;

	assign in_stall       = (state_q != S_IDLE);
	assign out_valid      = out_valid_q;
	assign result_address = result_address_q;
	assign status         = status_q;

	fehp_ram #(
		.DEPTH(MAX_EXTENTS),
		.WIDTH($bits(extent_t))
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = i_q[IDX_W-1:0];
		wr_en   = 1'b0;
		wr_addr = i_q[IDX_W-1:0];
		wr_data = rd_data;
		unique case (state_q)
			S_INIT: begin
				wr_en   = 1'b1;
				wr_addr = '0;
				wr_data = '{start_addr: base_q, end_addr: base_q + size_q};
			end
			S_A_RD, S_F_RD, S_CI_RD: begin
				rd_en = (i_q < count_q);
			end
			S_A_CHK: begin
				wr_en   = fits_carve;
				wr_data = '{start_addr: rd_data.start_addr,
					end_addr: rd_data.end_addr - need_q[31:0]};
			end
			S_SHD_RD, S_CP_RD: begin
				rd_en   = (j_q < count_q);
				rd_addr = j_q[IDX_W-1:0];
			end
			S_SHD_WR: begin
				wr_en   = 1'b1;
				wr_addr = IDX_W'(j_q - CNT_W'(1));
			end
			S_F_CHK: begin
				wr_en = (fend_q == rd_data.start_addr) || (rd_data.end_addr == from_q);
				if (fend_q == rd_data.start_addr) begin
					wr_data = '{start_addr: from_q, end_addr: rd_data.end_addr};
				end else begin
					wr_data = '{start_addr: rd_data.start_addr, end_addr: fend_q};
				end
			end
			S_SHU_RD: begin
				rd_en   = (j_q != '0);
				rd_addr = IDX_W'(j_q - CNT_W'(1));
			end
			S_SHU_WR: begin
				wr_en   = 1'b1;
				wr_addr = j_q[IDX_W-1:0];
			end
			S_F_HEAD: begin
				wr_en   = 1'b1;
				wr_addr = '0;
				wr_data = '{start_addr: from_q, end_addr: fend_q};
			end
			S_CJ_RD: begin
				rd_addr = j_q[IDX_W-1:0];
				rd_en   = (j_q < count_q) && (j_q != i_q);
				wr_en   = (j_q >= count_q);
				wr_data = '{start_addr: si_q, end_addr: ei_q};
			end
			S_CJ_CHK: begin
				wr_addr = j_q[IDX_W-1:0];
				wr_en   = (si_q == rd_data.end_addr) || (ei_q == rd_data.start_addr);
				if (si_q == rd_data.end_addr) begin
					wr_data = '{start_addr: rd_data.start_addr, end_addr: ei_q};
				end else begin
					wr_data = '{start_addr: rd_data.end_addr, end_addr: rd_data.end_addr};
				end
			end
			S_CP_CHK: begin
				wr_addr = w_q[IDX_W-1:0];
				wr_en   = (rd_data.start_addr != rd_data.end_addr);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			base_q       <= '0;
			size_q       <= '0;
			count_q      <= CNT_W'(1);
			frees_q      <= '0;
			i_q          <= '0;
			j_q          <= '0;
			w_q          <= '0;
			retry_q      <= 1'b0;
			cret_alloc_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			// hold a stalled result, raise valid when a new one is loaded
			out_valid_q <= (out_valid_q && out_stall) || (state_q == S_DONE && out_free);
			unique case (state_q)
				S_INIT: begin
					count_q <= CNT_W'(1);
					frees_q <= '0;
					state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (cfg_write) begin
						if (cfg_index == REG_HEAP_BASE) begin
							base_q <= cfg_data;
						end else begin
							size_q <= cfg_data;
						end
						state_q <= S_INIT;
					end else if (in_valid) begin
						need_q       <= {1'b0, request_size} + {1'b0, HEADER_BYTES};
						from_q       <= user_address - HEADER_BYTES;
						fend_q       <= user_address + request_size;
						i_q          <= '0;
						total_q      <= '0;
						retry_q      <= 1'b0;
						res_addr_q   <= '0;
						res_status_q <= ST_OK;
						state_q      <= (kind == KIND_ALLOC) ? S_A_RD : S_F_RD;
					end
				end
				S_A_RD: begin
					if (i_q < count_q) begin
						state_q <= S_A_CHK;
					end else if (!retry_q && total_q >= TOTAL_W'(need_q)) begin
						cret_alloc_q <= 1'b1;
						i_q          <= '0;
						state_q      <= S_CI_RD;
					end else begin
						res_status_q <= ST_NO_SPACE;
						state_q      <= S_DONE;
					end
				end
				S_A_CHK: begin
					total_q <= total_q + TOTAL_W'(avail);
					priority if (fits_carve) begin
						res_addr_q <= rd_data.end_addr - need_q[31:0] + HEADER_BYTES;
						state_q    <= S_DONE;
					end else if (fits_whole) begin
						res_addr_q <= rd_data.start_addr + HEADER_BYTES;
						j_q        <= i_q + CNT_W'(1);
						state_q    <= S_SHD_RD;
					end else begin
						i_q     <= i_q + CNT_W'(1);
						state_q <= S_A_RD;
					end
				end
				S_SHD_RD: begin
					if (j_q < count_q) begin
						state_q <= S_SHD_WR;
					end else begin
						count_q <= count_q - CNT_W'(1);
						state_q <= S_DONE;
					end
				end
				S_SHD_WR: begin
					j_q     <= j_q + CNT_W'(1);
					state_q <= S_SHD_RD;
				end
				S_F_RD: begin
					if (i_q < count_q) begin
						state_q <= S_F_CHK;
					end else if (count_q >= CNT_W'(MAX_EXTENTS)) begin
						res_status_q <= ST_TABLE_FULL;
						state_q      <= S_F_POST;
					end else begin
						j_q     <= count_q;
						state_q <= S_SHU_RD;
					end
				end
				S_F_CHK: begin
					if ((fend_q == rd_data.start_addr) || (rd_data.end_addr == from_q)) begin
						state_q <= S_F_POST;
					end else begin
						i_q     <= i_q + CNT_W'(1);
						state_q <= S_F_RD;
					end
				end
				S_SHU_RD: begin
					state_q <= (j_q == '0) ? S_F_HEAD : S_SHU_WR;
				end
				S_SHU_WR: begin
					j_q     <= j_q - CNT_W'(1);
					state_q <= S_SHU_RD;
				end
				S_F_HEAD: begin
					count_q <= count_q + CNT_W'(1);
					state_q <= S_F_POST;
				end
				S_F_POST: begin
					if (frees_inc > MERGE_PERIOD) begin
						frees_q      <= '0;
						cret_alloc_q <= 1'b0;
						i_q          <= '0;
						state_q      <= S_CI_RD;
					end else begin
						frees_q <= frees_inc;
						state_q <= S_DONE;
					end
				end
				S_CI_RD: begin
					if (i_q < count_q) begin
						state_q <= S_CI_LD;
					end else begin
						j_q     <= '0;
						w_q     <= '0;
						state_q <= S_CP_RD;
					end
				end
				S_CI_LD: begin
					si_q    <= rd_data.start_addr;
					ei_q    <= rd_data.end_addr;
					j_q     <= '0;
					state_q <= S_CJ_RD;
				end
				S_CJ_RD: begin
					priority if (j_q >= count_q) begin
						i_q     <= i_q + CNT_W'(1);
						state_q <= S_CI_RD;
					end else if (j_q == i_q) begin
						j_q <= j_q + CNT_W'(1);
					end else begin
						state_q <= S_CJ_CHK;
					end
				end
				S_CJ_CHK: begin
					priority if (si_q == rd_data.end_addr) begin
						si_q <= ei_q;
					end else if (ei_q == rd_data.start_addr) begin
						ei_q <= rd_data.end_addr;
					end else begin
					end
					j_q     <= j_q + CNT_W'(1);
					state_q <= S_CJ_RD;
				end
				S_CP_RD: begin
					if (j_q < count_q) begin
						state_q <= S_CP_CHK;
					end else begin
						count_q <= w_q;
						if (cret_alloc_q) begin
							retry_q <= 1'b1;
							i_q     <= '0;
							total_q <= '0;
							state_q <= S_A_RD;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_CP_CHK: begin
					if (rd_data.start_addr != rd_data.end_addr) begin
						w_q <= w_q + CNT_W'(1);
					end
					j_q     <= j_q + CNT_W'(1);
					state_q <= S_CP_RD;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_INIT;
				end
			endcase
		end
	end

	// hold the result until the downstream side takes it
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			result_address_q <= res_addr_q;
			status_q         <= res_status_q;
		end
	end

endmodule
